/* src/cthl_pkg.sv */
// shared types and constants of the connection table lookup
package cthl_pkg;

  // default sizes
  localparam int unsigned DEF_BUCKETS    = 256;
  localparam int unsigned DEF_WAYS       = 4;
  localparam int unsigned DEF_VALUE_BITS = 64;

  // key and field widths
  localparam int unsigned KEY_W      = 96;
  localparam int unsigned KEY_BYTES  = 12;
  localparam int unsigned ADDRS_W    = 64;
  localparam int unsigned PORTS_W    = 32;
  localparam int unsigned VALUE_W    = 64;

  // low 16 bits of the fnv-1a prime and offset basis
  localparam logic [15:0] HASH_MULT_LO = 16'h01B3;
  localparam logic [15:0] FNV_BASIS_LO = 16'h2325;

  // request kinds
  localparam logic [1:0] MODE_GET = 2'd0;
  localparam logic [1:0] MODE_SET = 2'd1;
  localparam logic [1:0] MODE_DEL = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_MISSING = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_MATCH,
    S_UPDATE
  } state_e;

endpackage

/* src/connection_table_hash_lookup.sv */
// connection table with fnv-1a hashed buckets and a fixed number of ways
//
// One request is taken when start is high and busy is low; its single result
// appears on status_o and value_out_o for one cycle with done_o high, after
// S_HASH, S_READ, S_MATCH and S_UPDATE. busy falls in that same cycle, and only
// then can a new request be taken. The hash takes one key byte a cycle over the
// 12 key bytes, then the bucket row is read from the table memory, compared and
// written back if a set or delete changes it. After reset busy stays high while
// a clearing pass empties every row. The receiver cannot stall the result.
module connection_table_hash_lookup
  import cthl_pkg::*;
#(
  parameter int unsigned BUCKETS    = DEF_BUCKETS,
  parameter int unsigned WAYS       = DEF_WAYS,
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode_i,
  input  logic [31:0]        src_addr_i,
  input  logic [15:0]        src_port_i,
  input  logic [31:0]        dst_addr_i,
  input  logic [15:0]        dst_port_i,
  input  logic [VALUE_W-1:0] value_in_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [VALUE_W-1:0] value_out_o
);

  localparam int unsigned HB     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned WAY_W  = 1 + ADDRS_W + PORTS_W + VALUE_BITS;
  localparam int unsigned ROW_W  = WAYS * WAY_W;
  localparam int unsigned VLD_B  = WAY_W - 1;
  localparam int unsigned ADDR_L = PORTS_W + VALUE_BITS;
  localparam int unsigned PORT_L = VALUE_BITS;

  state_e                state_q, state_d;
  logic [3:0]            cnt_q, cnt_d;
  logic [HB-1:0]         clr_q, clr_d;
  logic [HB-1:0]         hash_q, hash_d;
  logic [KEY_W-1:0]      key_q, key_d;
  logic [1:0]            mode_q, mode_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic                  hit_q, hit_d;
  logic [WW-1:0]         hitw_q, hitw_d;
  logic                  free_q, free_d;
  logic [WW-1:0]         freew_q, freew_d;
  logic                  done_q, done_d;
  logic [1:0]            status_q, status_d;
  logic [VALUE_W-1:0]    vout_q, vout_d;

  logic [ROW_W-1:0]      mem [BUCKETS];
  logic [ROW_W-1:0]      row_q;
  logic                  mem_re, mem_we;
  logic [HB-1:0]         mem_addr;
  logic [ROW_W-1:0]      mem_wdata;

  logic [HB-1:0]         hx;
  logic [HB+8:0]         prod;
  logic [HB-1:0]         bucket;
  logic [ADDRS_W-1:0]    key_addrs;
  logic [PORTS_W-1:0]    key_ports;
  logic [WAY_W-1:0]      way;

  // one fnv-1a byte step on the low hash bits
  assign hx     = hash_q ^ HB'(key_q[7:0]);
  assign prod   = (HB+9)'(hx) * (HB+9)'(HASH_MULT_LO);
  assign bucket = hash_q & HB'(BUCKETS - 1);

  // key packed as {dst_port, dst_addr, src_port, src_addr}
  assign key_addrs = {key_q[31:0], key_q[79:48]};
  assign key_ports = {key_q[47:32], key_q[95:80]};

  // sequencer next state and datapath
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    clr_d     = clr_q;
    hash_d    = hash_q;
    key_d     = key_q;
    mode_d    = mode_q;
    val_d     = val_q;
    hit_d     = hit_q;
    hitw_d    = hitw_q;
    free_d    = free_q;
    freew_d   = freew_q;
    done_d    = 1'b0;
    status_d  = status_q;
    vout_d    = vout_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = bucket;
    mem_wdata = row_q;
    way       = '0;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + HB'(1);
        if (clr_q == HB'(BUCKETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          key_d   = {dst_port_i, dst_addr_i, src_port_i, src_addr_i};
          mode_d  = mode_i;
          val_d   = value_in_i[VALUE_BITS-1:0];
          hash_d  = HB'(FNV_BASIS_LO);
          cnt_d   = '0;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        // rotate the key a byte a cycle; twelve steps bring it back in place
        hash_d = prod[HB-1:0];
        key_d  = {key_q[7:0], key_q[KEY_W-1:8]};
        cnt_d  = cnt_q + 4'd1;
        if (cnt_q == 4'(KEY_BYTES - 1)) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        mem_re  = 1'b1;
        state_d = S_MATCH;
      end
      S_MATCH: begin
        // first matching way and first free way
        hit_d   = 1'b0;
        hitw_d  = '0;
        free_d  = 1'b0;
        freew_d = '0;
        for (int w = 0; w < WAYS; w++) begin
          if (row_q[w*WAY_W + VLD_B]) begin
            if (!hit_d && row_q[w*WAY_W + ADDR_L +: ADDRS_W] == key_addrs &&
                row_q[w*WAY_W + PORT_L +: PORTS_W] == key_ports) begin
              hit_d  = 1'b1;
              hitw_d = WW'(w);
            end
          end else if (!free_d) begin
            free_d  = 1'b1;
            freew_d = WW'(w);
          end
        end
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        done_d   = 1'b1;
        status_d = STAT_MISSING;
        vout_d   = '0;
        case (mode_q)
          MODE_GET: begin
            if (hit_q) begin
              status_d = STAT_OK;
              vout_d   = VALUE_W'(row_q[hitw_q*WAY_W +: VALUE_BITS]);
            end
          end
          MODE_SET: begin
            if (hit_q) begin
              mem_we = 1'b1;
              mem_wdata[hitw_q*WAY_W +: VALUE_BITS] = val_q;
              status_d = STAT_OK;
            end else if (free_q) begin
              way    = {1'b1, key_addrs, key_ports, val_q};
              mem_we = 1'b1;
              mem_wdata[freew_q*WAY_W +: WAY_W] = way;
              status_d = STAT_OK;
            end else begin
              status_d = STAT_FULL;
            end
          end
          MODE_DEL: begin
            if (hit_q) begin
              mem_we = 1'b1;
              mem_wdata[hitw_q*WAY_W + VLD_B] = 1'b0;
              status_d = STAT_OK;
            end
          end
          default: begin
            status_d = STAT_MISSING;
          end
        endcase
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hash_q   <= hash_d;
    key_q    <= key_d;
    mode_q   <= mode_d;
    val_q    <= val_d;
    hit_q    <= hit_d;
    hitw_q   <= hitw_d;
    free_q   <= free_d;
    freew_q  <= freew_d;
    status_q <= status_d;
    vout_q   <= vout_d;
  end

  // bucket row memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      row_q <= mem[mem_addr];
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign value_out_o = vout_q;

endmodule
